// ----- design/u8dec_pkg.sv -----
`timescale 1ns / 1ps

package u8dec_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;
    localparam int CNT_W  = 3;
    localparam int DEPTH  = 4;
    localparam int IDX_W  = 2;

    localparam logic [CP_W-1:0] CP_REPL = 21'h00FFFD;

    localparam logic [CNT_W-1:0] NEED_ONE   = 3'd1;
    localparam logic [CNT_W-1:0] NEED_TWO   = 3'd2;
    localparam logic [CNT_W-1:0] NEED_THREE = 3'd3;
    localparam logic [CNT_W-1:0] NEED_FOUR  = 3'd4;

    typedef struct packed {
        logic load;
        logic step;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic out_busy;
    } status_t;

    // total bytes a lead asks for, including itself; bad leads count as one
    function automatic logic [CNT_W-1:0] lead_need(input logic [BYTE_W-1:0] b);
        logic [CNT_W-1:0] n;
        begin
            if ((b & 8'h80) == 8'h00)
                n = NEED_ONE;
            else if ((b & 8'hE0) == 8'hC0)
                n = NEED_TWO;
            else if ((b & 8'hF0) == 8'hE0)
                n = NEED_THREE;
            else if ((b & 8'hF8) == 8'hF0)
                n = NEED_FOUR;
            else
                n = NEED_ONE;
            return n;
        end
    endfunction

    function automatic logic lead_bad(input logic [BYTE_W-1:0] b);
        return ((b & 8'hC0) == 8'h80) || ((b & 8'hF8) == 8'hF8);
    endfunction

    function automatic logic is_follower(input logic [BYTE_W-1:0] b);
        return (b & 8'hC0) == 8'h80;
    endfunction

endpackage

// ----- design/u8dec_ctrl.sv -----
`timescale 1ns / 1ps

module u8dec_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  u8dec_pkg::status_t status,
    output u8dec_pkg::cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EVAL = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_stall = (state_reg != S_IDLE);
    assign cmd.load = (state_reg == S_IDLE) && in_valid;
    assign cmd.step = (state_reg == S_EVAL) && !status.out_busy;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (cmd.step && status.done)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ----- design/u8dec_datapath.sv -----
`timescale 1ns / 1ps

module u8dec_datapath
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  u8dec_pkg::cmd_t                   cmd,
    output u8dec_pkg::status_t                status,
    input  logic [u8dec_pkg::BYTE_W-1:0]      in_byte,
    input  logic                              text_end,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [u8dec_pkg::CP_W-1:0]        code_point,
    output logic                              run_last,
    output logic                              text_done
);

    logic [u8dec_pkg::BYTE_W-1:0] buf_reg  [u8dec_pkg::DEPTH];
    logic [u8dec_pkg::BYTE_W-1:0] buf_next [u8dec_pkg::DEPTH];
    logic [u8dec_pkg::CNT_W-1:0]  cnt_reg;
    logic [u8dec_pkg::CNT_W-1:0]  cnt_next;
    logic                         last_reg;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [u8dec_pkg::CP_W-1:0]   cp_reg;
    logic [u8dec_pkg::CP_W-1:0]   cp_next;
    logic                         run_last_reg;
    logic                         run_last_next;
    logic                         text_done_reg;
    logic                         text_done_next;

    logic [u8dec_pkg::CNT_W-1:0]  need;
    logic                         bad;
    logic                         incomplete;
    logic                         fol_ok;
    logic [u8dec_pkg::CP_W-1:0]   cp_dec;
    logic [u8dec_pkg::CNT_W-1:0]  drop;
    logic [u8dec_pkg::CNT_W-1:0]  rem;
    logic [u8dec_pkg::BYTE_W-1:0] lead2;
    logic [u8dec_pkg::CNT_W-1:0]  need2;
    logic                         more;
    logic                         emit;
    logic                         done;
    logic [u8dec_pkg::CNT_W-1:0]  src;

    assign need       = u8dec_pkg::lead_need(buf_reg[0]);
    assign bad        = u8dec_pkg::lead_bad(buf_reg[0]);
    assign incomplete = (cnt_reg < need);

    always_comb
    begin
        fol_ok = 1'b1;
        if (need >= u8dec_pkg::NEED_TWO && !u8dec_pkg::is_follower(buf_reg[1]))
            fol_ok = 1'b0;
        if (need >= u8dec_pkg::NEED_THREE && !u8dec_pkg::is_follower(buf_reg[2]))
            fol_ok = 1'b0;
        if (need >= u8dec_pkg::NEED_FOUR && !u8dec_pkg::is_follower(buf_reg[3]))
            fol_ok = 1'b0;
    end

    always_comb
    begin
        cp_dec = '0;
        unique case (need)
            u8dec_pkg::NEED_ONE:
                cp_dec = {13'd0, buf_reg[0]};
            u8dec_pkg::NEED_TWO:
                cp_dec = {10'd0, buf_reg[0][4:0], buf_reg[1][5:0]};
            u8dec_pkg::NEED_THREE:
                cp_dec = {5'd0, buf_reg[0][3:0], buf_reg[1][5:0], buf_reg[2][5:0]};
            u8dec_pkg::NEED_FOUR:
                cp_dec = {buf_reg[0][2:0], buf_reg[1][5:0], buf_reg[2][5:0],
                          buf_reg[3][5:0]};
            default:
                cp_dec = u8dec_pkg::CP_REPL;
        endcase
    end

    // malformed sequences consume only the lead
    assign drop  = (bad || !fol_ok) ? u8dec_pkg::NEED_ONE : need;
    assign rem   = cnt_reg - drop;
    assign lead2 = buf_reg[drop[u8dec_pkg::IDX_W-1:0]];
    assign need2 = u8dec_pkg::lead_need(lead2);
    // next round gives a result unless it only waits for more bytes
    assign more  = (rem != '0) && !((rem < need2) && !last_reg);

    always_comb
    begin
        if (incomplete)
        begin
            emit = last_reg;
            done = 1'b1;
        end
        else
        begin
            emit = 1'b1;
            done = !more;
        end
    end

    assign status.done     = done;
    assign status.out_busy = out_valid_reg && out_stall;

    always_comb
    begin
        for (int i = 0; i < u8dec_pkg::DEPTH; i++)
            buf_next[i] = buf_reg[i];
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        cp_next        = cp_reg;
        run_last_next  = run_last_reg;
        text_done_next = text_done_reg;
        src            = '0;
        if (cmd.load)
        begin
            buf_next[cnt_reg[u8dec_pkg::IDX_W-1:0]] = in_byte;
            cnt_next = cnt_reg + 3'd1;
        end
        else if (cmd.step)
        begin
            if (incomplete)
            begin
                if (last_reg)
                    cnt_next = '0;
            end
            else
            begin
                for (int i = 0; i < u8dec_pkg::DEPTH; i++)
                begin
                    src = u8dec_pkg::CNT_W'(i) + drop;
                    buf_next[i] = buf_reg[src[u8dec_pkg::IDX_W-1:0]];
                end
                cnt_next = rem;
            end
            if (emit)
            begin
                out_valid_next = 1'b1;
                cp_next        = (incomplete || bad || !fol_ok) ? u8dec_pkg::CP_REPL
                                                                 : cp_dec;
                run_last_next  = done;
                text_done_next = done && last_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < u8dec_pkg::DEPTH; i++)
            buf_reg[i] <= buf_next[i];
        if (cmd.load)
            last_reg <= text_end;
        cp_reg        <= cp_next;
        run_last_reg  <= run_last_next;
        text_done_reg <= text_done_next;
    end

    assign out_valid  = out_valid_reg;
    assign code_point = cp_reg;
    assign run_last   = run_last_reg;
    assign text_done  = text_done_reg;

endmodule

// ----- design/utf8_stream_decoder_top.sv -----
// a word is taken while the fsm is idle; decode rounds then register its results, if any
// rounds run until done; each gives one result unless it only waits for more bytes
// no new word is taken before the last round; a stalled output holds the decode round
// the 4-byte pending buffer and its count live in the datapath, set by the control fsm
// reset: asynchronous active low rst_n clears the fsm, buffer count and output valid
`timescale 1ns / 1ps

module utf8_stream_decoder_top
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [u8dec_pkg::BYTE_W-1:0] in_byte,
    input  logic                         text_end,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [u8dec_pkg::CP_W-1:0]   code_point,
    output logic                         run_last,
    output logic                         text_done
);

    u8dec_pkg::cmd_t    cmd;
    u8dec_pkg::status_t status;

    u8dec_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    u8dec_datapath u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .in_byte    (in_byte),
        .text_end   (text_end),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .code_point (code_point),
        .run_last   (run_last),
        .text_done  (text_done)
    );

endmodule

// ----- design/u8dec_checker.sv -----
`timescale 1ns / 1ps

module u8dec_checker
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [u8dec_pkg::CP_W-1:0]   code_point,
    input logic                         run_last,
    input logic                         text_done
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(code_point)
            && $stable(run_last) && $stable(text_done))
        else $error("stalled result changed");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && text_done |-> run_last)
        else $error("text_done without run_last");

    // a taken word keeps the input blocked for its decode
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken twice in a row");

    // more results of the same word pending
    a_busy_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !run_last |-> in_stall)
        else $error("input open with results pending");

endmodule

bind utf8_stream_decoder_top u8dec_checker u_chk (.*);
